@@ rtl/acpd_pkg.sv @@
// Shared types and constants for the arithmetic and collision helper device.
// Used by the channel interfaces, the serial arithmetic units and the top level.
package acpd_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [4:0]  addr_t;
  typedef logic [2:0]  rd_sel_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  localparam int unsigned REG_COUNT = 32;

  // Access modes
  localparam mode_t MODE_WRITE = 2'd0;
  localparam mode_t MODE_READ  = 2'd1;
  localparam mode_t MODE_TICK  = 2'd2;

  // Read map (low three address bits)
  localparam rd_sel_t RD_QUO_HI  = 3'd0;
  localparam rd_sel_t RD_QUO_LO  = 3'd1;
  localparam rd_sel_t RD_REM_HI  = 3'd2;
  localparam rd_sel_t RD_REM_LO  = 3'd3;
  localparam rd_sel_t RD_ROOT_HI = 3'd4;
  localparam rd_sel_t RD_ROOT_LO = 3'd5;
  localparam rd_sel_t RD_RANDOM  = 3'd6;
  localparam rd_sel_t RD_OCTANT  = 3'd7;

  // Register file addresses with a fixed role
  localparam addr_t ADDR_TMR_HI = 5'h10;
  localparam addr_t ADDR_TMR_LO = 5'h11;
  localparam addr_t ADDR_NMI_EN = 5'h12;

  localparam word_t LFSR_RESET = 16'h00ff;
  localparam byte_t DIV0_BYTE  = 8'hff;

  // Octant codes: first letter is sign of dy (N: dy <= 0, P: dy > 0), second of dx,
  // last says which axis dominates.
  localparam byte_t OCT_NN_X = 8'h00;
  localparam byte_t OCT_PN_X = 8'h01;
  localparam byte_t OCT_PN_Y = 8'h02;
  localparam byte_t OCT_PP_Y = 8'h03;
  localparam byte_t OCT_NP_X = 8'h04;
  localparam byte_t OCT_PP_X = 8'h05;
  localparam byte_t OCT_NN_Y = 8'h06;
  localparam byte_t OCT_NP_Y = 8'h07;
  localparam byte_t OCT_MISS = 8'hff;

endpackage

@@ rtl/acpd_if.sv @@
// Valid/ready channel interfaces for the helper device: access items in, results out.
// Depends on acpd_pkg for the payload types.
interface acpd_in_if import acpd_pkg::*; ;
  logic  valid;
  logic  ready;
  mode_t mode;
  addr_t address;
  byte_t write_byte;

  modport source (output valid, output mode, output address, output write_byte,
                  input ready);
  modport sink   (input valid, input mode, input address, input write_byte,
                  output ready);
endinterface

interface acpd_out_if import acpd_pkg::*; ;
  logic  valid;
  logic  ready;
  byte_t read_byte;
  logic  nmi_pulse;

  modport source (output valid, output read_byte, output nmi_pulse, input ready);
  modport sink   (input valid, input read_byte, input nmi_pulse, output ready);
endinterface

@@ rtl/arith_collision_protection_device.sv @@
// Top level of the arithmetic and collision helper device: register file, LFSR,
// NMI timer, sequencer and output register. Uses acpd_pkg, acpd_if, acpd_div,
// acpd_sqrt and acpd_oct.
//
// Usage:
//   in_chan carries one bus access or timer tick per item (mode, address,
//   write_byte); out_chan returns exactly one result per item (read_byte,
//   nmi_pulse). Both channels move an item when valid and ready are high.
//   Writes, ticks, random reads and reads with a zero divisor have their result
//   registered by the sequencer and then loaded into the output register.
//   Quotient, remainder and square root reads first run 16 single-bit steps of
//   the shared serial divider or root unit, then hand off. Octant reads pass
//   through the two-stage octant unit. The block is ready for the next item in
//   the cycle after the result is loaded.
//   The block accepts a new item while its last result still waits in the
//   output register; a stalled receiver holds that result and the block then
//   waits before loading the next one.
//   Synchronous reset clears the register file, sets the LFSR to 0x00ff,
//   clears the NMI countdown and empties the output register.
module arith_collision_protection_device import acpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  acpd_in_if.sink           in_chan,
  acpd_out_if.source        out_chan
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  byte_t      reg_r [REG_COUNT];
  word_t      lfsr_r;
  word_t      nmi_cnt_r;
  rd_sel_t    rd_sel_r;
  byte_t      res_byte_r;
  byte_t      res_byte_nxt;
  logic       res_nmi_r;
  logic       res_nmi_nxt;
  logic       out_valid_r;
  byte_t      out_byte_r;
  logic       out_nmi_r;

  logic       accept;
  logic       out_free;
  rd_sel_t    rd_sel;
  word_t      op1;
  word_t      op2;
  word_t      op3;
  logic       div_start;
  logic       sqrt_start;
  logic       oct_start;
  logic       div_busy;
  logic       sqrt_busy;
  logic       oct_busy;
  logic       div_done;
  logic       sqrt_done;
  logic       oct_done;
  word_t      quotient;
  word_t      remainder;
  word_t      root;
  byte_t      oct_code;
  logic       unit_done;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign rd_sel   = in_chan.address[2:0];

  assign op1 = {reg_r[0], reg_r[1]};
  assign op2 = {reg_r[2], reg_r[3]};
  assign op3 = {reg_r[4], reg_r[5]};

  acpd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (op1),
    .divisor   (op2),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  acpd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (op3),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (root)
  );

  acpd_oct u_oct (
    .clk   (clk),
    .rst_n (rst_n),
    .start (oct_start),
    .rad   ({reg_r[6], reg_r[7]}),
    .y1    ({reg_r[8], reg_r[9]}),
    .x1    ({reg_r[10], reg_r[11]}),
    .y2    ({reg_r[12], reg_r[13]}),
    .x2    ({reg_r[14], reg_r[15]}),
    .busy  (oct_busy),
    .done  (oct_done),
    .code  (oct_code)
  );

  assign unit_done = div_done || sqrt_done || oct_done;

  // Decode the accepted item: start a unit or produce the result at once.
  always_comb begin
    div_start    = 1'b0;
    sqrt_start   = 1'b0;
    oct_start    = 1'b0;
    state_nxt    = state_r;
    res_byte_nxt = res_byte_r;
    res_nmi_nxt  = res_nmi_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_byte_nxt = '0;
          res_nmi_nxt  = 1'b0;
          state_nxt    = S_PUT;
          if (in_chan.mode == MODE_READ) begin
            unique case (rd_sel) inside
              RD_QUO_HI, RD_QUO_LO, RD_REM_HI, RD_REM_LO: begin
                if (op2 == '0) begin
                  res_byte_nxt = DIV0_BYTE;
                end else begin
                  div_start = 1'b1;
                  state_nxt = S_RUN;
                end
              end
              RD_ROOT_HI, RD_ROOT_LO: begin
                sqrt_start = 1'b1;
                state_nxt  = S_RUN;
              end
              RD_RANDOM: begin
                res_byte_nxt = lfsr_r[7:0];
              end
              default: begin
                oct_start = 1'b1;
                state_nxt = S_RUN;
              end
            endcase
          end else if (in_chan.mode == MODE_TICK) begin
            if (nmi_cnt_r == '0) begin
              res_nmi_nxt = reg_r[ADDR_NMI_EN][0];
            end
          end
        end
      end
      S_RUN: begin
        if (unit_done) begin
          state_nxt = S_PUT;
          unique case (rd_sel_r)
            RD_QUO_HI:  res_byte_nxt = quotient[15:8];
            RD_QUO_LO:  res_byte_nxt = quotient[7:0];
            RD_REM_HI:  res_byte_nxt = remainder[15:8];
            RD_REM_LO:  res_byte_nxt = remainder[7:0];
            RD_ROOT_HI: res_byte_nxt = root[15:8];
            RD_ROOT_LO: res_byte_nxt = root[7:0];
            default:    res_byte_nxt = oct_code;
          endcase
        end
      end
      S_PUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lfsr_r    <= LFSR_RESET;
      nmi_cnt_r <= '0;
      res_nmi_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        reg_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      res_nmi_r <= res_nmi_nxt;
      if (accept) begin
        // Writes and reads clock the LFSR; ticks and unused modes leave it.
        if (in_chan.mode == MODE_WRITE || in_chan.mode == MODE_READ) begin
          lfsr_r <= {lfsr_r[14:0], lfsr_r[1] ^ lfsr_r[8] ^ lfsr_r[12]};
        end
        if (in_chan.mode == MODE_WRITE) begin
          reg_r[in_chan.address] <= in_chan.write_byte;
        end
        if (in_chan.mode == MODE_TICK) begin
          if (nmi_cnt_r == '0) begin
            nmi_cnt_r <= {reg_r[ADDR_TMR_HI], reg_r[ADDR_TMR_LO]};
          end else begin
            nmi_cnt_r <= nmi_cnt_r - 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_byte_r <= res_byte_nxt;
    if (accept) begin
      rd_sel_r <= rd_sel;
    end
  end

  // Output register: load when the slot frees, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_PUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PUT && out_free) begin
      out_byte_r <= res_byte_r;
      out_nmi_r  <= res_nmi_r;
    end
  end

  assign in_chan.ready      = (state_r == S_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_byte = out_byte_r;
  assign out_chan.nmi_pulse = out_nmi_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted item did not leave idle");

  a_units_quiet_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !(div_busy || sqrt_busy || oct_busy))
    else $error("arithmetic unit busy while sequencer idle");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({div_busy, sqrt_busy, oct_busy}))
    else $error("more than one arithmetic unit busy");

  a_nmi_without_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.nmi_pulse |-> out_chan.read_byte == '0)
    else $error("NMI result carries read data");

endmodule

@@ rtl/acpd_div.sv @@
// Signed 16-bit divider, restoring, one quotient bit per cycle.
// Depends on acpd_pkg for word_t.
module acpd_div import acpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  busy,
  output logic  done,
  output word_t quotient,
  output word_t remainder
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  word_t       rem_r;
  word_t       quo_r;
  word_t       dvs_r;
  logic        qneg_r;
  logic        rneg_r;

  logic [16:0] shifted;
  logic [17:0] diff;
  word_t       rem_nxt;
  word_t       quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[15]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    if (!diff[17]) begin
      rem_nxt = diff[15:0];
      quo_nxt = {quo_r[14:0], 1'b1};
    end else begin
      rem_nxt = shifted[15:0];
      quo_nxt = {quo_r[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Work on magnitudes; the most negative dividend maps to 0x8000 unsigned.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend[15] ? word_t'(-dividend) : dividend;
      dvs_r  <= divisor[15] ? word_t'(-divisor) : divisor;
      rem_r  <= '0;
      qneg_r <= dividend[15] ^ divisor[15];
      rneg_r <= dividend[15];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = qneg_r ? word_t'(-quo_r) : quo_r;
  assign remainder = rneg_r ? word_t'(-rem_r) : rem_r;

endmodule

@@ rtl/acpd_sqrt.sv @@
// Integer square root of a 16-bit value scaled by 65536, one root bit per cycle.
// Depends on acpd_pkg for word_t.
module acpd_sqrt import acpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t radicand,
  output logic  busy,
  output logic  done,
  output word_t root
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  word_t       rad_r;
  logic [16:0] rem_r;
  word_t       root_r;

  logic [18:0] shifted;
  logic [19:0] trial;
  logic [16:0] rem_nxt;
  word_t       root_nxt;

  // Bring in two radicand bits per step; the low 16 bits of the scaled value are zero.
  always_comb begin
    shifted = {rem_r, rad_r[15:14]};
    trial   = {1'b0, shifted} - {2'b00, root_r, 2'b01};
    if (!trial[19]) begin
      rem_nxt  = trial[16:0];
      root_nxt = {root_r[14:0], 1'b1};
    end else begin
      rem_nxt  = shifted[16:0];
      root_nxt = {root_r[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[13:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = {root_r[15:1], 1'b0};

endmodule

@@ rtl/acpd_oct.sv @@
// Collision octant unit: differences in a first stage, range check and octant in a second.
// Depends on acpd_pkg for word_t, byte_t and the octant codes.
module acpd_oct import acpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t rad,
  input  word_t y1,
  input  word_t x1,
  input  word_t y2,
  input  word_t x2,
  output logic  busy,
  output logic  done,
  output byte_t code
);

  logic        a_vld_r;
  logic        done_r;
  logic [16:0] dx_r;
  logic [16:0] dy_r;
  byte_t       code_r;

  logic [16:0] adx;
  logic [16:0] ady;
  logic [17:0] sum;
  logic [17:0] dif;
  logic        dx_le;
  logic        dy_le;
  byte_t       code_nxt;

  always_comb begin
    adx   = dx_r[16] ? 17'(-dx_r) : dx_r;
    ady   = dy_r[16] ? 17'(-dy_r) : dy_r;
    sum   = {dy_r[16], dy_r} + {dx_r[16], dx_r};
    dif   = {dy_r[16], dy_r} - {dx_r[16], dx_r};
    dx_le = dx_r[16] || (dx_r == '0);
    dy_le = dy_r[16] || (dy_r == '0);
    if ((adx > {1'b0, rad}) || (ady > {1'b0, rad})) begin
      code_nxt = OCT_MISS;
    end else if (dy_le && dx_le) begin
      code_nxt = !dif[17] ? OCT_NN_X : OCT_NN_Y;
    end else if (dy_le) begin
      code_nxt = !sum[17] ? OCT_NP_X : OCT_NP_Y;
    end else if (dx_le) begin
      code_nxt = (!sum[17] && (sum != '0)) ? OCT_PN_Y : OCT_PN_X;
    end else begin
      code_nxt = (!dif[17] && (dif != '0)) ? OCT_PP_Y : OCT_PP_X;
    end
  end

  // Points are sampled at start; rad is not, and stays put until the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      a_vld_r <= start;
      done_r  <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dx_r <= {1'b0, x2} - {1'b0, x1};
      dy_r <= {1'b0, y2} - {1'b0, y1};
    end
    if (a_vld_r) begin
      code_r <= code_nxt;
    end
  end

  assign busy = a_vld_r;
  assign done = done_r;
  assign code = code_r;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for arith_collision_protection_device: directed and random bus accesses and
// timer ticks go in, each result is checked against a behavioral copy of the device.
// Depends on acpd_pkg, the channel interfaces in acpd_if and the device RTL.
module testbench;
  import acpd_pkg::*;

  localparam mode_t MODE_SPARE   = 2'd3;
  localparam int    RANDOM_ITEMS = 750;
  localparam int    CYCLE_LIMIT  = 400000;
  localparam int    DRAIN_CYCLES = 40;

  typedef struct packed {
    mode_t mode;
    addr_t address;
    byte_t write_byte;
  } access_t;

  typedef struct packed {
    byte_t read_byte;
    logic  nmi_pulse;
  } result_t;

  logic clk;
  logic rst_n;

  acpd_in_if  access_ch ();
  acpd_out_if result_ch ();

  arith_collision_protection_device dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (access_ch),
    .out_chan (result_ch)
  );

  // Device state as the accesses see it
  byte_t regs [REG_COUNT];
  word_t lfsr_state;
  word_t countdown;

  access_t queued_accesses [$];
  result_t due_results [$];
  access_t in_flight;
  int      total_accesses;
  int      accepted_count;
  int      mismatches;
  int      cycle_count;

  // Sender burst shaping
  int burst_left;
  int gap_left;

  // Receiver stall shaping
  int stall_style;
  int style_left;
  int hold_left;

  function automatic word_t next_lfsr(word_t v);
    return {v[14:0], v[1] ^ v[8] ^ v[12]};
  endfunction

  function automatic word_t reg_word(addr_t idx);
    return {regs[idx], regs[idx + 5'd1]};
  endfunction

  function automatic byte_t octant_of();
    int rad, ya, xa, yb, xb, dx, dy, adx, ady;
    rad = int'(reg_word(5'd6));
    ya  = int'(reg_word(5'd8));
    xa  = int'(reg_word(5'd10));
    yb  = int'(reg_word(5'd12));
    xb  = int'(reg_word(5'd14));
    dx  = xb - xa;
    dy  = yb - ya;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (adx > rad || ady > rad) return OCT_MISS;
    if (ya >= yb) begin
      if (xa >= xb) return (dy >= dx) ? OCT_NN_X : OCT_NN_Y;
      return (dy >= -dx) ? OCT_NP_X : OCT_NP_Y;
    end
    if (xa >= xb) return (dy > -dx) ? OCT_PN_Y : OCT_PN_X;
    return (dy > dx) ? OCT_PP_Y : OCT_PP_X;
  endfunction

  task automatic emulate_access(input access_t acc, output result_t res);
    byte_t   rnd;
    int      dividend, divisor, q, r;
    word_t   quot, rem, root;
    logic [31:0] radicand;
    longint  trial;
    rd_sel_t sel;
    res = '0;
    case (acc.mode)
      MODE_WRITE: begin
        regs[acc.address] = acc.write_byte;
        lfsr_state = next_lfsr(lfsr_state);
      end
      MODE_READ: begin
        rnd = lfsr_state[7:0];
        lfsr_state = next_lfsr(lfsr_state);
        dividend = int'($signed(reg_word(5'd0)));
        divisor  = int'($signed(reg_word(5'd2)));
        if (divisor == 0) begin
          quot = {DIV0_BYTE, DIV0_BYTE};
          rem  = {DIV0_BYTE, DIV0_BYTE};
        end else begin
          q = dividend / divisor;
          r = dividend % divisor;
          quot = q[15:0];
          rem  = r[15:0];
        end
        // Bit-by-bit root search, then drop bit 0
        radicand = {reg_word(5'd4), 16'h0000};
        root = '0;
        for (int b = 15; b >= 0; b--) begin
          trial = longint'(root | (16'h1 << b));
          if (trial * trial <= longint'(radicand)) root = root | (16'h1 << b);
        end
        root[0] = 1'b0;
        sel = acc.address[2:0];
        case (sel)
          RD_QUO_HI:  res.read_byte = quot[15:8];
          RD_QUO_LO:  res.read_byte = quot[7:0];
          RD_REM_HI:  res.read_byte = rem[15:8];
          RD_REM_LO:  res.read_byte = rem[7:0];
          RD_ROOT_HI: res.read_byte = root[15:8];
          RD_ROOT_LO: res.read_byte = root[7:0];
          RD_RANDOM:  res.read_byte = rnd;
          default:    res.read_byte = octant_of();
        endcase
      end
      MODE_TICK: begin
        if (countdown == 16'h0000) begin
          res.nmi_pulse = regs[ADDR_NMI_EN][0];
          countdown = {regs[ADDR_TMR_HI], regs[ADDR_TMR_LO]};
        end else begin
          countdown = countdown - 16'h0001;
        end
      end
      default: ;
    endcase
  endtask

  task automatic enqueue(mode_t m, addr_t a, byte_t d);
    access_t acc;
    acc.mode = m;
    acc.address = a;
    acc.write_byte = d;
    queued_accesses.push_back(acc);
  endtask

  task automatic put_word(addr_t a, word_t w);
    enqueue(MODE_WRITE, a, w[15:8]);
    enqueue(MODE_WRITE, a + 5'd1, w[7:0]);
  endtask

  // Random high address bits on reads; only the low three select
  function automatic addr_t read_addr(rd_sel_t sel);
    return {2'($urandom_range(0, 3)), sel};
  endfunction

  function automatic word_t clamp_coord(int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hffff;
    return word_t'(v);
  endfunction

  function automatic word_t pick_word(int choice);
    case (choice)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      4: return word_t'($urandom_range(0, 15));
      default: return word_t'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  task automatic build_stimulus();
    int    rad, span, xa, ya, dx, dy, n;
    word_t w;
    // Reads straight out of reset: zero divisor, zero root, first random byte, octant
    enqueue(MODE_READ, {2'b00, RD_QUO_HI}, 8'h00);
    enqueue(MODE_READ, {2'b00, RD_REM_LO}, 8'h00);
    enqueue(MODE_READ, {2'b00, RD_ROOT_HI}, 8'h00);
    enqueue(MODE_READ, {2'b00, RD_RANDOM}, 8'h00);
    enqueue(MODE_READ, {2'b00, RD_OCTANT}, 8'h00);
    // Most negative over minus one
    put_word(5'd0, 16'h8000);
    put_word(5'd2, 16'hffff);
    enqueue(MODE_READ, {2'b00, RD_QUO_HI}, 8'h00);
    enqueue(MODE_READ, {2'b00, RD_QUO_LO}, 8'h00);
    enqueue(MODE_READ, {2'b11, RD_REM_HI}, 8'h00);
    enqueue(MODE_READ, {2'b11, RD_REM_LO}, 8'h00);
    // Largest root
    put_word(5'd4, 16'hffff);
    enqueue(MODE_READ, {2'b11, RD_ROOT_HI}, 8'h00);
    enqueue(MODE_READ, {2'b10, RD_ROOT_LO}, 8'h00);
    // Timer: reload of one with NMI enabled, then count down and expire again
    enqueue(MODE_WRITE, ADDR_TMR_HI, 8'h00);
    enqueue(MODE_WRITE, ADDR_TMR_LO, 8'h01);
    enqueue(MODE_WRITE, ADDR_NMI_EN, 8'hff);
    repeat (3) enqueue(MODE_TICK, 5'h1f, 8'hff);
    enqueue(MODE_SPARE, 5'h1f, 8'hff);

    while (queued_accesses.size() < RANDOM_ITEMS + 24) begin
      case ($urandom_range(0, 7))
        0, 1: begin
          w = pick_word($urandom_range(0, 7));
          if ($urandom_range(0, 3) != 0) put_word(5'd0, w);
          put_word(5'd2, pick_word($urandom_range(0, 7)));
          n = $urandom_range(1, 4);
          repeat (n) enqueue(MODE_READ, read_addr(rd_sel_t'($urandom_range(0, 3))), 8'h00);
        end
        2: begin
          put_word(5'd4, pick_word($urandom_range(1, 7)));
          enqueue(MODE_READ, read_addr(RD_ROOT_HI), 8'h00);
          enqueue(MODE_READ, read_addr(RD_ROOT_LO), 8'h00);
        end
        3, 4: begin
          case ($urandom_range(0, 4))
            0: rad = 0;
            1: rad = 65535;
            4: rad = $urandom_range(0, 16'hffff);
            default: rad = $urandom_range(1, 500);
          endcase
          span = (rad > 1000) ? 65535 : rad + 2;
          xa = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 16'hffff);
          ya = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 16'hffff);
          dx = int'($urandom_range(0, 2 * span)) - span;
          case ($urandom_range(0, 5))
            0: dy = dx;
            1: dy = -dx;
            default: dy = int'($urandom_range(0, 2 * span)) - span;
          endcase
          put_word(5'd6, word_t'(rad));
          put_word(5'd8, word_t'(ya));
          put_word(5'd10, word_t'(xa));
          put_word(5'd12, clamp_coord(ya + dy));
          put_word(5'd14, clamp_coord(xa + dx));
          enqueue(MODE_READ, read_addr(RD_OCTANT), 8'h00);
        end
        5: begin
          enqueue(MODE_WRITE, ADDR_TMR_HI,
                  ($urandom_range(0, 7) == 0) ? byte_t'($urandom_range(0, 255)) : 8'h00);
          enqueue(MODE_WRITE, ADDR_TMR_LO, byte_t'($urandom_range(0, 6)));
          enqueue(MODE_WRITE, ADDR_NMI_EN, byte_t'($urandom_range(0, 255)));
          n = $urandom_range(1, 10);
          repeat (n)
            enqueue(MODE_TICK, addr_t'($urandom_range(0, 31)), byte_t'($urandom_range(0, 255)));
        end
        6: begin
          n = $urandom_range(1, 3);
          repeat (n) enqueue(MODE_READ, read_addr(RD_RANDOM), 8'h00);
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n)
            enqueue(($urandom_range(0, 15) == 0) ? MODE_SPARE : mode_t'($urandom_range(0, 2)),
                    addr_t'($urandom_range(0, 31)), byte_t'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    access_ch.valid = 1'b0;
    access_ch.mode = MODE_WRITE;
    access_ch.address = '0;
    access_ch.write_byte = '0;
    result_ch.ready = 1'b0;
    for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
    lfsr_state = LFSR_RESET;
    countdown = '0;
    accepted_count = 0;
    mismatches = 0;
    cycle_count = 0;
    burst_left = 0;
    gap_left = 0;
    stall_style = 0;
    style_left = 0;
    hold_left = 0;
    build_stimulus();
    total_accesses = queued_accesses.size();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_count < total_accesses) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("arith_collision_protection_device: match");
    else
      $display("arith_collision_protection_device: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("arith_collision_protection_device: mismatch");
      $finish;
    end
  end

  // Sender: bursts of items with random gaps
  always @(posedge clk) begin : drive
    result_t res;
    access_t acc;
    bit      free;
    if (!rst_n) begin
      access_ch.valid <= 1'b0;
    end else begin
      free = !access_ch.valid;
      if (access_ch.valid && access_ch.ready) begin
        emulate_access(in_flight, res);
        due_results.push_back(res);
        accepted_count++;
        free = 1'b1;
      end
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
          access_ch.valid <= 1'b0;
        end else if (queued_accesses.size() > 0) begin
          acc = queued_accesses.pop_front();
          in_flight = acc;
          access_ch.valid <= 1'b1;
          access_ch.mode <= acc.mode;
          access_ch.address <= acc.address;
          access_ch.write_byte <= acc.write_byte;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          access_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result, then pick the next ready level
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: read_byte %02h nmi_pulse %0b",
                     result_ch.read_byte, result_ch.nmi_pulse);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (want.read_byte !== result_ch.read_byte ||
              want.nmi_pulse !== result_ch.nmi_pulse) begin
            if (mismatches < 10)
              $display("result %0d: read_byte exp %02h got %02h, nmi_pulse exp %0b got %0b",
                       accepted_count - due_results.size() - 1, want.read_byte,
                       result_ch.read_byte, want.nmi_pulse, result_ch.nmi_pulse);
            mismatches++;
          end
        end
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 120);
      end else begin
        style_left--;
      end
      case (stall_style)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= (cycle_count[1:0] != 2'b00);
        2: result_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          // hold ready low for long stretches now and then
          if (hold_left > 0) begin
            hold_left--;
            result_ch.ready <= 1'b0;
          end else begin
            result_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(5, 40);
          end
        end
      endcase
    end
  end

endmodule

@@ sim.f @@
rtl/acpd_pkg.sv
rtl/acpd_if.sv
rtl/acpd_div.sv
rtl/acpd_sqrt.sv
rtl/acpd_oct.sv
rtl/arith_collision_protection_device.sv
tb/sv/testbench.sv
